/* hdl/lpft_pkg.sv */
package lpft_pkg;

   // Default table size and fixed constants
   localparam int unsigned TABLE_DEPTH_DEF = 256;
   localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
   localparam logic [8:0] PORT_LIMIT_RESET = 9'd127;

   // Request codes
   localparam logic [1:0] REQ_REMOVE = 2'd0;
   localparam logic [1:0] REQ_ADD = 2'd1;
   localparam logic [1:0] REQ_CHARGE = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic is_listening;
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic charging_on;
   } req_item_type;

   typedef struct packed {
      logic filter_enabled;
      logic [8:0] port_total;
      logic already_present;
      logic not_found;
      logic table_full;
      logic changed_notice;
   } rsp_item_type;

   // One table entry
   typedef struct packed {
      logic valid;
      logic [15:0] port;
   } entry_type;

   // Outcome of one table scan and update
   typedef struct packed {
      logic present;
      logic missing;
      logic full;
      logic inserted;
      logic removed;
   } scan_res_type;

endpackage

/* hdl/listening_port_filter_table.sv */
// Socket add/remove beats that count scan the whole table with one comparator:
//   the scan runs through S_SCAN, S_DRAIN and S_UPDATE, then T_OUT loads the response register.
// Charging and ignored beats go straight to T_OUT; no new request is taken until the response is loaded.
// Reset (synchronous) empties the table by a clearing pass over every entry,
//   with req_ready low; count and charging clear, filter flag sets, limit = 127.
module listening_port_filter_table #(
   parameter int unsigned TABLE_DEPTH = lpft_pkg::TABLE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input lpft_pkg::req_item_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output lpft_pkg::rsp_item_type rsp_data,
   input logic csr_we,
   input logic [8:0] csr_wdata
);

   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned CMPW = (CW > 9) ? CW : 9;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_BUSY = 3'b010,
      T_OUT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic charging_ff, charging_in;
   logic flag_ff, flag_in;
   logic [8:0] limit_ff;
   lpft_pkg::rsp_item_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   lpft_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic scan_ready, scan_done, scan_start;
   lpft_pkg::scan_res_type scan_res;

   logic accept, counted, slot_free;
   logic [CMPW-1:0] count_ext, count_in_ext, limit_ext;

   lpft_scan #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .start_i(scan_start),
      .add_i(req_data.req_type == lpft_pkg::REQ_ADD),
      .key_i(req_data.local_port),
      .ready_o(scan_ready),
      .done_o(scan_done),
      .res_o(scan_res)
   );

   assign req_ready = (state_ff == T_IDLE) && scan_ready;
   assign accept = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Qualify socket events
   assign counted = ((req_data.req_type == lpft_pkg::REQ_ADD) ||
                     (req_data.req_type == lpft_pkg::REQ_REMOVE)) &&
                    req_data.is_listening &&
                    (req_data.local_addr != lpft_pkg::LOOPBACK_ADDR) &&
                    (req_data.local_port != 16'd0);
   assign scan_start = accept && counted;

   assign count_ext = CMPW'(count_ff);
   assign count_in_ext = CMPW'(count_in);
   assign limit_ext = CMPW'(limit_ff);

   // Item control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      charging_in = charging_ff;
      flag_in = flag_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (counted) begin
                  state_in = T_BUSY;
               end else begin
                  res_in = '0;
                  if ((req_data.req_type == lpft_pkg::REQ_CHARGE) && flag_ff) begin
                     charging_in = req_data.charging_on;
                     flag_in = !req_data.charging_on && (count_ext <= limit_ext);
                     res_in.changed_notice = 1'b1;
                  end
                  res_in.filter_enabled = flag_in;
                  res_in.port_total = count_ext[8:0];
                  state_in = T_OUT;
               end
            end
         end
         T_BUSY: begin
            if (scan_done) begin
               priority if (scan_res.inserted) begin
                  count_in = count_ff + CW'(1);
               end else if (scan_res.removed) begin
                  count_in = count_ff - CW'(1);
               end
               flag_in = !charging_ff && (count_in_ext <= limit_ext);
               res_in.filter_enabled = flag_in;
               res_in.port_total = count_in_ext[8:0];
               res_in.already_present = scan_res.present;
               res_in.not_found = scan_res.missing;
               res_in.table_full = scan_res.full;
               res_in.changed_notice = 1'b1;
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         count_ff <= '0;
         charging_ff <= 1'b0;
         flag_ff <= 1'b1;
         limit_ff <= lpft_pkg::PORT_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         charging_ff <= charging_in;
         flag_ff <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hdl/lpft_scan.sv */
module lpft_scan #(
   parameter int unsigned TABLE_DEPTH = lpft_pkg::TABLE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic start_i,
   input logic add_i,
   input logic [15:0] key_i,
   output logic ready_o,
   output logic done_o,
   output lpft_pkg::scan_res_type res_o
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE = 5'b00010,
      S_SCAN = 5'b00100,
      S_DRAIN = 5'b01000,
      S_UPDATE = 5'b10000
   } state_type;

   lpft_pkg::entry_type mem [TABLE_DEPTH];

   state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic add_ff, add_in;
   logic [15:0] key_ff, key_in;
   logic rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff;
   lpft_pkg::entry_type rd_data_ff;
   logic match_ff, match_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   logic free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;

   logic hit_now, free_now;
   logic rd_en;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   lpft_pkg::entry_type wr_data;

   // Shared comparator on the registered read beat
   assign hit_now = rd_pend_ff && rd_data_ff.valid && (rd_data_ff.port == key_ff);
   assign free_now = rd_pend_ff && !rd_data_ff.valid;

   assign ready_o = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      add_in = add_ff;
      key_in = key_ff;
      rd_pend_in = 1'b0;
      rd_en = 1'b0;
      match_in = match_ff;
      match_idx_in = match_idx_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      done_o = 1'b0;
      res_o = '0;

      if (hit_now && !match_ff) begin
         match_in = 1'b1;
         match_idx_in = rd_idx_ff;
      end
      if (free_now && !free_ff) begin
         free_in = 1'b1;
         free_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               addr_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start_i) begin
               add_in = add_i;
               key_in = key_i;
               addr_in = '0;
               match_in = 1'b0;
               free_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en = 1'b1;
            rd_pend_in = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            done_o = 1'b1;
            state_in = S_IDLE;
            if (add_ff) begin
               res_o.present = match_ff;
               res_o.full = !match_ff && !free_ff;
               res_o.inserted = !match_ff && free_ff;
               wr_en = !match_ff && free_ff;
               wr_addr = free_idx_ff;
               wr_data.valid = 1'b1;
               wr_data.port = key_ff;
            end else begin
               res_o.missing = !match_ff;
               res_o.removed = match_ff;
               wr_en = match_ff;
               wr_addr = match_idx_ff;
               wr_data.valid = 1'b0;
               wr_data.port = key_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         rd_pend_ff <= 1'b0;
         match_ff <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rd_pend_ff <= rd_pend_in;
         match_ff <= match_in;
         free_ff <= free_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      add_ff <= add_in;
      key_ff <= key_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff <= free_idx_in;
      rd_idx_ff <= addr_ff;
   end

   // Port table: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

endmodule
